FILE: hdl/vgts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vgts_pkg
// Shared types, constants and helpers of the voxel grid trilinear sampler.
// ----------------------------------------------------------------------------
package vgts_pkg;

	localparam int GRID_X = 32;
	localparam int GRID_Y = 32;
	localparam int GRID_Z = 32;
	localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;
	localparam int ADDR_W = $clog2(CELLS);

	// operation codes
	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_SCALE_X  = 3'd3,
		REG_SCALE_Y  = 3'd4,
		REG_SCALE_Z  = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_READ,
		B_SAMPLE,
		B_DRAIN
	} back_state_t;

	// one classified item between front and back
	typedef struct packed {
		op_t                op;
		logic               hit;
		logic [ADDR_W-1:0]  addr;
		logic signed [31:0] wdata;
		logic signed [11:0] lc_x;
		logic signed [11:0] lc_y;
		logic signed [11:0] lc_z;
		logic [15:0]        f_x;
		logic [15:0]        f_y;
		logic [15:0]        f_z;
	} entry_t;

	typedef struct packed {
		logic clear_done;
	} back_status_t;

	function automatic logic in_grid(input logic signed [16:0] x,
		input logic signed [16:0] y, input logic signed [16:0] z);
		in_grid = (x >= 0) && (x < 17'(GRID_X)) && (y >= 0) && (y < 17'(GRID_Y))
			&& (z >= 0) && (z < 17'(GRID_Z));
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [16:0] x,
		input logic signed [16:0] y, input logic signed [16:0] z);
		cell_addr = ADDR_W'(z) * ADDR_W'(GRID_X * GRID_Y) + ADDR_W'(y) * ADDR_W'(GRID_X)
			+ ADDR_W'(x);
	endfunction

endpackage
`default_nettype wire

FILE: hdl/vgts_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vgts_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module vgts_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire vgts_pkg::entry_t push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  valid,
	output vgts_pkg::entry_t      head
);

	vgts_pkg::entry_t mem_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head  = mem_q[rp_q];

	// store beat
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

FILE: hdl/vgts_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vgts_front
// Accepts items, holds configuration, maps sample points to grid corners.
// ----------------------------------------------------------------------------
module vgts_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               run,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         opcode,
	input  wire logic signed [15:0] voxel_x,
	input  wire logic signed [15:0] voxel_y,
	input  wire logic signed [15:0] voxel_z,
	input  wire logic signed [31:0] write_value,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic signed [31:0] point_z,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	output logic                    push,
	output vgts_pkg::entry_t        push_data,
	input  wire logic               q_full
);

	logic signed [31:0] org_x_q, org_y_q, org_z_q;
	logic [30:0]        scl_x_q, scl_y_q, scl_z_q;

	logic               en;
	logic               acc;
	logic               v_s1, v_s2, v_s3;
	vgts_pkg::op_t      op_s1, op_s2;
	logic               ihit_s1, ihit_s2;
	logic [vgts_pkg::ADDR_W-1:0] addr_s1, addr_s2;
	logic signed [31:0] wd_s1, wd_s2;
	logic signed [32:0] dx_s1, dy_s1, dz_s1;
	logic signed [63:0] gx_s2, gy_s2, gz_s2;
	vgts_pkg::entry_t   ent_s3;

	logic signed [63:0] sx, sy, sz;
	logic               hx, hy, hz;

	// whole pipe moves unless the last stage is blocked
	assign en       = !v_s3 || !q_full;
	assign in_ready = en && run;
	assign acc      = in_valid && in_ready;
	assign push     = v_s3 && !q_full;
	assign push_data = ent_s3;

	// hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= '0;
			org_y_q <= '0;
			org_z_q <= '0;
			scl_x_q <= '0;
			scl_y_q <= '0;
			scl_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vgts_pkg::REG_ORIGIN_X: org_x_q <= cfg_data;
				vgts_pkg::REG_ORIGIN_Y: org_y_q <= cfg_data;
				vgts_pkg::REG_ORIGIN_Z: org_z_q <= cfg_data;
				vgts_pkg::REG_SCALE_X:  scl_x_q <= cfg_data[30:0];
				vgts_pkg::REG_SCALE_Y:  scl_y_q <= cfg_data[30:0];
				vgts_pkg::REG_SCALE_Z:  scl_z_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: offsets and index checks
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= vgts_pkg::op_t'(opcode);
			ihit_s1 <= vgts_pkg::in_grid(17'(voxel_x), 17'(voxel_y), 17'(voxel_z));
			addr_s1 <= vgts_pkg::cell_addr(17'(voxel_x), 17'(voxel_y), 17'(voxel_z));
			wd_s1   <= write_value;
			dx_s1   <= 33'(point_x) - 33'(org_x_q);
			dy_s1   <= 33'(point_y) - 33'(org_y_q);
			dz_s1   <= 33'(point_z) - 33'(org_z_q);
		end
	end

	// stage 2: grid coordinates in Q32.32
	always_ff @(posedge clk) begin
		if (en) begin
			op_s2   <= op_s1;
			ihit_s2 <= ihit_s1;
			addr_s2 <= addr_s1;
			wd_s2   <= wd_s1;
			gx_s2   <= 64'(dx_s1 * $signed({1'b0, scl_x_q}));
			gy_s2   <= 64'(dy_s1 * $signed({1'b0, scl_y_q}));
			gz_s2   <= 64'(dz_s1 * $signed({1'b0, scl_z_q}));
		end
	end

	// bounds test and shift by one half
	always_comb begin
		hx = !gx_s2[63] && (gx_s2 <= $signed({32'(vgts_pkg::GRID_X), 32'd0}));
		hy = !gy_s2[63] && (gy_s2 <= $signed({32'(vgts_pkg::GRID_Y), 32'd0}));
		hz = !gz_s2[63] && (gz_s2 <= $signed({32'(vgts_pkg::GRID_Z), 32'd0}));
		sx = gx_s2 - 64'sd2147483648;
		sy = gy_s2 - 64'sd2147483648;
		sz = gz_s2 - 64'sd2147483648;
	end

	// stage 3: classified item
	always_ff @(posedge clk) begin
		if (en) begin
			ent_s3.op    <= op_s2;
			ent_s3.hit   <= (op_s2 == vgts_pkg::OP_SAMPLE) ? (hx && hy && hz) : ihit_s2;
			ent_s3.addr  <= addr_s2;
			ent_s3.wdata <= wd_s2;
			ent_s3.lc_x  <= sx[43:32];
			ent_s3.lc_y  <= sy[43:32];
			ent_s3.lc_z  <= sz[43:32];
			ent_s3.f_x   <= sx[31:16];
			ent_s3.f_y   <= sy[31:16];
			ent_s3.f_z   <= sz[31:16];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/vgts_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vgts_back
// Owns the voxel store: clears it, runs writes, reads and corner blends.
// ----------------------------------------------------------------------------
module vgts_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire vgts_pkg::entry_t   q_head,
	output logic                    pop,
	output vgts_pkg::back_status_t  status,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      result_value,
	output logic                    hit
);

	localparam int AW = vgts_pkg::ADDR_W;

	logic signed [31:0] mem [vgts_pkg::CELLS];
	logic signed [31:0] rdata_q;

	vgts_pkg::back_state_t state_q, state_d;
	vgts_pkg::entry_t      cur_q;
	logic [AW-1:0]         clr_q;
	logic [2:0]            cnt_q;
	logic                  out_free;
	logic                  out_set;

	logic                  m_we;
	logic [AW-1:0]         m_addr;
	logic signed [31:0]    m_wd;
	logic                  issue;

	// corner selection
	logic signed [16:0]    cx, cy, cz;
	logic [16:0]           wx, wy, wz;
	logic                  c_in;

	logic                  v_s1, v_s2, v_s3, last_s1, last_s2, last_s3;
	logic                  in_s1, in_s2;
	logic [32:0]           wxy_s1;
	logic [16:0]           wz_s1;
	logic [32:0]           w_s2;
	logic signed [31:0]    data_s2;
	logic signed [65:0]    prod_s3;
	logic signed [66:0]    acc_q, acc_d;
	logic signed [34:0]    shr;
	logic signed [31:0]    sat;

	assign out_free          = !out_valid || out_ready;
	assign status.clear_done = (state_q != vgts_pkg::B_CLEAR);

	// load the output register: direct results, read data or finished blend
	assign out_set = (pop && !(q_head.op == vgts_pkg::OP_READ)
			&& !(q_head.op == vgts_pkg::OP_SAMPLE && q_head.hit))
		|| (state_q == vgts_pkg::B_READ)
		|| (state_q == vgts_pkg::B_DRAIN && last_s3);

	// single-port store
	always_ff @(posedge clk) begin
		if (m_we) begin
			mem[m_addr] <= m_wd;
		end
		rdata_q <= mem[m_addr];
	end

	// corner of the current count: x from bit 2, y from bit 1, z from bit 0
	always_comb begin
		cx = 17'(cur_q.lc_x) + 17'(cnt_q[2]);
		cy = 17'(cur_q.lc_y) + 17'(cnt_q[1]);
		cz = 17'(cur_q.lc_z) + 17'(cnt_q[0]);
		wx = cnt_q[2] ? {1'b0, cur_q.f_x} : 17'd65536 - {1'b0, cur_q.f_x};
		wy = cnt_q[1] ? {1'b0, cur_q.f_y} : 17'd65536 - {1'b0, cur_q.f_y};
		wz = cnt_q[0] ? {1'b0, cur_q.f_z} : 17'd65536 - {1'b0, cur_q.f_z};
		c_in = vgts_pkg::in_grid(cx, cy, cz);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vgts_pkg::B_CLEAR: begin
				if (clr_q == AW'(vgts_pkg::CELLS - 1)) state_d = vgts_pkg::B_IDLE;
			end
			vgts_pkg::B_IDLE: begin
				if (q_valid && out_free) begin
					if (q_head.op == vgts_pkg::OP_READ) state_d = vgts_pkg::B_READ;
					else if (q_head.op == vgts_pkg::OP_SAMPLE && q_head.hit)
						state_d = vgts_pkg::B_SAMPLE;
				end
			end
			vgts_pkg::B_READ:   state_d = vgts_pkg::B_IDLE;
			vgts_pkg::B_SAMPLE: begin
				if (cnt_q == 3'd7) state_d = vgts_pkg::B_DRAIN;
			end
			vgts_pkg::B_DRAIN: begin
				if (last_s3) state_d = vgts_pkg::B_IDLE;
			end
			default: state_d = vgts_pkg::B_IDLE;
		endcase
	end

	// store controls
	always_comb begin
		m_we   = 1'b0;
		m_addr = q_head.addr;
		m_wd   = q_head.wdata;
		pop    = 1'b0;
		issue  = 1'b0;
		unique case (state_q)
			vgts_pkg::B_CLEAR: begin
				m_we   = 1'b1;
				m_addr = clr_q;
				m_wd   = '0;
			end
			vgts_pkg::B_IDLE: begin
				pop  = q_valid && out_free;
				m_we = pop && (q_head.op == vgts_pkg::OP_WRITE) && q_head.hit;
			end
			vgts_pkg::B_SAMPLE: begin
				issue  = 1'b1;
				m_addr = vgts_pkg::cell_addr(cx, cy, cz);
			end
			default: ;
		endcase
	end

	// sum the terms and saturate
	always_comb begin
		acc_d = acc_q + 67'(prod_s3);
		shr   = acc_d[66:32];
		if (shr > 35'sd2147483647) sat = 32'sh7fffffff;
		else if (shr < -35'sd2147483648) sat = 32'sh80000000;
		else sat = shr[31:0];
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= vgts_pkg::B_CLEAR;
			clr_q     <= '0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == vgts_pkg::B_CLEAR) clr_q <= clr_q + AW'(1);
			cnt_q <= issue ? cnt_q + 3'd1 : 3'd0;
			v_s1  <= issue;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			if (out_set) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
		end
	end

	// result and blend datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_head;
			acc_q <= '0;
			if (!(q_head.op == vgts_pkg::OP_READ)) begin
				result_value <= '0;
				hit          <= q_head.hit && (q_head.op != vgts_pkg::OP_NONE);
			end
		end else if (v_s3) begin
			acc_q <= acc_d;
		end
		if (state_q == vgts_pkg::B_READ) begin
			result_value <= cur_q.hit ? rdata_q : '0;
			hit          <= cur_q.hit;
		end
		if (state_q == vgts_pkg::B_DRAIN && last_s3) begin
			result_value <= sat;
			hit          <= 1'b1;
		end
		last_s1 <= (cnt_q == 3'd7);
		in_s1   <= c_in;
		wxy_s1  <= 33'(wx * wy);
		wz_s1   <= wz;
		last_s2 <= last_s1 && v_s1;
		in_s2   <= in_s1;
		w_s2    <= 33'((50'(wxy_s1) * 50'(wz_s1)) >> 16);
		data_s2 <= rdata_q;
		last_s3 <= last_s2 && v_s2;
		prod_s3 <= in_s2 ? 66'(data_s2 * $signed({1'b0, w_s2})) : '0;
	end

endmodule
`default_nettype wire

FILE: hdl/voxel_grid_trilinear_sampler_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_grid_trilinear_sampler_top
// Voxel store of Q16.16 densities with write, read and trilinear sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_ready) carry an opcode, a voxel index, a write
//   value and a world point; each beat yields one output beat (out_valid/
//   out_ready) with result_value and hit, in order.
//   Configuration (origin, scale) is written through cfg_we/cfg_index/cfg_data
//   by the user only while the block is idle; the block does not enforce it.
//   A front pipeline of three stages maps points to grid corners and feeds a
//   two-entry queue; the back sequencer owns the single-port store.
//   A sample reads its eight corners from the store, one corner read per
//   cycle, then drains the blend pipe and returns to idle before the back
//   takes the next beat. Writes are taken back to back while the output
//   is free; a read passes through B_READ before the next beat is taken.
//   After reset the store is cleared one entry per cycle, all 32768 entries,
//   with in_ready low. A stalled receiver holds the output register; the queue
//   and front keep taking beats until the queue is full and stage 3 is blocked.
// ----------------------------------------------------------------------------
module voxel_grid_trilinear_sampler_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         opcode,
	input  wire logic signed [15:0] voxel_x,
	input  wire logic signed [15:0] voxel_y,
	input  wire logic signed [15:0] voxel_z,
	input  wire logic signed [31:0] write_value,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic signed [31:0] point_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      result_value,
	output logic                    hit,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	logic                   push, q_full, q_valid, pop;
	vgts_pkg::entry_t       push_data, q_head;
	vgts_pkg::back_status_t status;

	vgts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.run        (status.clear_done),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.voxel_x    (voxel_x),
		.voxel_y    (voxel_y),
		.voxel_z    (voxel_z),
		.write_value(write_value),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.push_data  (push_data),
		.q_full     (q_full)
	);

	vgts_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	vgts_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.pop         (pop),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_value(result_value),
		.hit         (hit)
	);

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench of the voxel grid trilinear sampler: directed and
// random writes, reads and samples are predicted in a model of the store and
// the blend arithmetic, and every output beat is compared in order.
// ----------------------------------------------------------------------------
module testbench;

	localparam int  CYCLE_LIMIT = 600000;
	localparam int  ONE_Q16     = 65536;

	typedef struct {
		logic signed [31:0] value;
		logic               hit;
	} outcome_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         opcode;
	logic signed [15:0] voxel_x, voxel_y, voxel_z;
	logic signed [31:0] write_value, point_x, point_y, point_z;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] result_value;
	logic               hit;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;

	// predictor state
	logic signed [31:0] density [0:vgts_pkg::CELLS-1];
	logic signed [31:0] org_x, org_y, org_z;
	logic [30:0]        scl_x, scl_y, scl_z;
	outcome_t           pending_q[$];
	int                 fail_count;
	int                 cycle_count;
	bit                 busy_mode;

	voxel_grid_trilinear_sampler_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .voxel_x(voxel_x), .voxel_y(voxel_y), .voxel_z(voxel_z),
		.write_value(write_value), .point_x(point_x), .point_y(point_y),
		.point_z(point_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_value(result_value), .hit(hit),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// random idle length: mostly none, some short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (busy_mode || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit inside_grid(int x, int y, int z);
		return x >= 0 && x < vgts_pkg::GRID_X && y >= 0 && y < vgts_pkg::GRID_Y
			&& z >= 0 && z < vgts_pkg::GRID_Z;
	endfunction

	function automatic int cell_of(int x, int y, int z);
		return z * vgts_pkg::GRID_X * vgts_pkg::GRID_Y + y * vgts_pkg::GRID_X + x;
	endfunction

	function automatic longint corner_density(int x, int y, int z);
		if (!inside_grid(x, y, z)) return 0;
		return longint'(density[cell_of(x, y, z)]);
	endfunction

	// map one axis to a lower corner and the two Q0.16 weights
	function automatic void map_axis(input logic signed [31:0] p, input logic signed [31:0] org,
		input logic [30:0] scl, input int res, output bit ok, output int lc,
		output longint w0, output longint w1);
		longint g, s, f;
		g = (longint'(p) - longint'(org)) * longint'(scl);
		ok = (g >= 0) && (g <= (longint'(res) <<< 32));
		s = g - 64'sh8000_0000;
		lc = int'(s >>> 32);
		f = (s - (longint'(lc) <<< 32)) >>> 16;
		w0 = ONE_Q16 - f;
		w1 = f;
	endfunction

	// expected result of one beat; writes update the store copy
	function automatic outcome_t predict_beat(logic [1:0] op, int vx, int vy, int vz,
		logic signed [31:0] wv, logic signed [31:0] px, logic signed [31:0] py,
		logic signed [31:0] pz);
		outcome_t o;
		bit okx, oky, okz;
		int lx, ly, lz;
		longint wx[2], wy[2], wz[2];
		longint wgt;
		logic signed [79:0] acc, term, r;
		o.value = 0;
		o.hit = 1'b0;
		case (op)
			vgts_pkg::OP_WRITE: begin
				if (inside_grid(vx, vy, vz)) begin
					density[cell_of(vx, vy, vz)] = wv;
					o.hit = 1'b1;
				end
			end
			vgts_pkg::OP_READ: begin
				if (inside_grid(vx, vy, vz)) begin
					o.value = density[cell_of(vx, vy, vz)];
					o.hit = 1'b1;
				end
			end
			vgts_pkg::OP_SAMPLE: begin
				map_axis(px, org_x, scl_x, vgts_pkg::GRID_X, okx, lx, wx[0], wx[1]);
				map_axis(py, org_y, scl_y, vgts_pkg::GRID_Y, oky, ly, wy[0], wy[1]);
				map_axis(pz, org_z, scl_z, vgts_pkg::GRID_Z, okz, lz, wz[0], wz[1]);
				if (okx && oky && okz) begin
					acc = 0;
					for (int i = 0; i < 2; i++)
						for (int j = 0; j < 2; j++)
							for (int k = 0; k < 2; k++) begin
								wgt = (wx[i] * wy[j] * wz[k]) >>> 16;
								term = 80'(corner_density(lx + i, ly + j, lz + k));
								term = term * 80'(wgt);
								acc = acc + term;
							end
					r = acc >>> 32;
					if (r > 80'sd2147483647) r = 80'sd2147483647;
					if (r < -80'sd2147483648) r = -80'sd2147483648;
					o.value = r[31:0];
					o.hit = 1'b1;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// drive one beat, hold it until accepted, then record the expectation
	task automatic send_beat(logic [1:0] op, logic signed [15:0] vx, logic signed [15:0] vy,
		logic signed [15:0] vz, logic signed [31:0] wv, logic signed [31:0] px,
		logic signed [31:0] py, logic signed [31:0] pz);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		opcode = op;
		voxel_x = vx;
		voxel_y = vy;
		voxel_z = vz;
		write_value = wv;
		point_x = px;
		point_y = py;
		point_z = pz;
		do @(posedge clk); while (!in_ready);
		pending_q.push_back(predict_beat(op, int'(vx), int'(vy), int'(vz), wv, px, py, pz));
	endtask

	// hold off input until every result is back
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(vgts_pkg::reg_idx_t idx, logic [31:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		case (idx)
			vgts_pkg::REG_ORIGIN_X: org_x = data;
			vgts_pkg::REG_ORIGIN_Y: org_y = data;
			vgts_pkg::REG_ORIGIN_Z: org_z = data;
			vgts_pkg::REG_SCALE_X:  scl_x = data[30:0];
			vgts_pkg::REG_SCALE_Y:  scl_y = data[30:0];
			vgts_pkg::REG_SCALE_Z:  scl_z = data[30:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_volume(logic signed [31:0] ox, logic signed [31:0] oy,
		logic signed [31:0] oz, logic [30:0] sx, logic [30:0] sy, logic [30:0] sz);
		drain();
		write_reg(vgts_pkg::REG_ORIGIN_X, ox);
		write_reg(vgts_pkg::REG_ORIGIN_Y, oy);
		write_reg(vgts_pkg::REG_ORIGIN_Z, oz);
		write_reg(vgts_pkg::REG_SCALE_X, {1'b0, sx});
		write_reg(vgts_pkg::REG_SCALE_Y, {1'b0, sy});
		write_reg(vgts_pkg::REG_SCALE_Z, {1'b0, sz});
	endtask

	// world coordinate that lands about one voxel around the volume
	function automatic logic signed [31:0] world_coord(logic signed [31:0] org,
		logic [30:0] scl, int res);
		longint t;
		if (scl == 0 || $urandom_range(0, 19) == 0) return $urandom;
		t = longint'($urandom_range(0, (res + 2) * ONE_Q16)) - ONE_Q16;
		return 32'(longint'(org) + (t * ONE_Q16) / longint'(scl));
	endfunction

	function automatic logic signed [15:0] grid_index(int res);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return -1;
		if (r == 1) return 16'(res);
		if (r == 2) return 16'($urandom);
		return 16'($urandom_range(0, res - 1));
	endfunction

	function automatic logic signed [31:0] some_density();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// reset values: zero scale maps every point onto coordinate zero
	task automatic test_reset_volume();
		send_beat(vgts_pkg::OP_READ, 0, 0, 0, 32'h1234_5678, 0, 0, 0);
		for (int n = 0; n < 6; n++)
			send_beat(vgts_pkg::OP_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom),
				$urandom, $urandom, $urandom, $urandom);
	endtask

	// edges of the grid, field extremes, saturation and the unused opcode
	task automatic test_directed();
		set_volume(0, 0, 0, 31'(ONE_Q16), 31'(ONE_Q16), 31'(ONE_Q16));
		send_beat(vgts_pkg::OP_WRITE, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0);
		send_beat(vgts_pkg::OP_WRITE, 31, 31, 31, 32'h8000_0000, 0, 0, 0);
		send_beat(vgts_pkg::OP_WRITE, -1, 0, 0, 32'h5555_5555, 0, 0, 0);
		send_beat(vgts_pkg::OP_WRITE, 0, 32, 0, 32'h5555_5555, 0, 0, 0);
		send_beat(vgts_pkg::OP_WRITE, -32768, 32767, 0, 32'hAAAA_AAAA, 0, 0, 0);
		send_beat(vgts_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0);
		send_beat(vgts_pkg::OP_READ, 31, 31, 31, 0, 0, 0, 0);
		send_beat(vgts_pkg::OP_READ, 0, 0, -32768, 0, 0, 0, 0);
		send_beat(vgts_pkg::OP_READ, 32767, 0, 0, 0, 0, 0, 0);
		send_beat(vgts_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0);
		send_beat(vgts_pkg::OP_SAMPLE, 0, 0, 0, 0, 32 << 16, 32 << 16, 32 << 16);
		send_beat(vgts_pkg::OP_SAMPLE, 0, 0, 0, 0, (32 << 16) + 1, 0, 0);
		send_beat(vgts_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, -1, 0);
		send_beat(vgts_pkg::OP_SAMPLE, 0, 0, 0, 0, 32'h8000, 32'h8000, 32'h8000);
		send_beat(vgts_pkg::OP_NONE, 1, 1, 1, 32'h7FFF_FFFF, 1 << 16, 1 << 16, 1 << 16);
		// all eight corners at the top value
		for (int n = 0; n < 8; n++)
			send_beat(vgts_pkg::OP_WRITE, 16'(1 + n[0]), 16'(1 + n[1]), 16'(1 + n[2]),
				32'h7FFF_FFFF, 0, 0, 0);
		send_beat(vgts_pkg::OP_SAMPLE, 0, 0, 0, 0, 2 << 16, 2 << 16, 2 << 16);
		send_beat(vgts_pkg::OP_SAMPLE, 0, 0, 0, 0, 32'h1_C000, 32'h2_4000, 32'h1_8001);
	endtask

	// mostly well-formed beats with random content, some pure noise
	task automatic test_random(int count);
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (n % 200 == 0) busy_mode = ($urandom_range(0, 2) == 0);
			if (r < 10)
				send_beat(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					$urandom, $urandom, $urandom, $urandom);
			else if (r < 45)
				send_beat(vgts_pkg::OP_WRITE, grid_index(vgts_pkg::GRID_X),
					grid_index(vgts_pkg::GRID_Y), grid_index(vgts_pkg::GRID_Z),
					some_density(), $urandom, $urandom, $urandom);
			else if (r < 60)
				send_beat(vgts_pkg::OP_READ, grid_index(vgts_pkg::GRID_X),
					grid_index(vgts_pkg::GRID_Y), grid_index(vgts_pkg::GRID_Z),
					$urandom, $urandom, $urandom, $urandom);
			else
				send_beat(vgts_pkg::OP_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom),
					$urandom,
					world_coord(org_x, scl_x, vgts_pkg::GRID_X),
					world_coord(org_y, scl_y, vgts_pkg::GRID_Y),
					world_coord(org_z, scl_z, vgts_pkg::GRID_Z));
		end
		busy_mode = 1'b0;
	endtask

	task automatic test_volumes();
		for (int p = 0; p < 3; p++) begin
			set_volume($urandom_range(0, 32'h0020_0000) - 32'h0010_0000,
				$urandom_range(0, 32'h0020_0000) - 32'h0010_0000,
				$urandom_range(0, 32'h0020_0000) - 32'h0010_0000,
				31'($urandom_range(32'h4000, 32'h4_0000)),
				31'($urandom_range(32'h4000, 32'h4_0000)),
				31'($urandom_range(32'h4000, 32'h4_0000)));
			test_random(330);
		end
	endtask

	// extreme origins and the largest scale
	task automatic test_extremes();
		set_volume(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		test_random(120);
		set_volume(32'h7FFF_FFFF, 32'h8000_0000, 0, 31'h7FFF_FFFF, 0, 31'(ONE_Q16));
		test_random(120);
	endtask

	// output stalls
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (busy_mode || $urandom_range(0, 2) != 0) begin
				out_ready = 1'b1;
			end else begin
				out_ready = 1'b0;
				repeat (idle_len()) @(negedge clk);
			end
		end
	end

	// compare each output beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected beat value %h hit %b", $time, result_value, hit);
				fail_count++;
			end else begin
				outcome_t e;
				e = pending_q.pop_front();
				if (result_value !== e.value) begin
					$display("%0t: result_value expected %h actual %h", $time, e.value,
						result_value);
					fail_count++;
				end
				if (hit !== e.hit) begin
					$display("%0t: hit expected %b actual %b", $time, e.hit, hit);
					fail_count++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = vgts_pkg::OP_NONE;
		voxel_x = 0;
		voxel_y = 0;
		voxel_z = 0;
		write_value = 0;
		point_x = 0;
		point_y = 0;
		point_z = 0;
		cfg_we = 1'b0;
		cfg_index = vgts_pkg::REG_ORIGIN_X;
		cfg_data = 0;
		fail_count = 0;
		cycle_count = 0;
		busy_mode = 1'b0;
		org_x = 0;
		org_y = 0;
		org_z = 0;
		scl_x = 0;
		scl_y = 0;
		scl_z = 0;
		for (int n = 0; n < vgts_pkg::CELLS; n++) density[n] = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_volume();
		test_directed();
		test_volumes();
		test_extremes();
		drain();

		if (fail_count == 0 && pending_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
